// ----- hw/rtl/gyro_bias_calibrate_integrate_macros.svh -----
// Assertion macros for the gyro bias/integrate block
`ifndef GYRO_BIAS_CALIBRATE_INTEGRATE_MACROS_SVH
`define GYRO_BIAS_CALIBRATE_INTEGRATE_MACROS_SVH
`ifndef SYNTHESIS
`define GBI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GBI_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define GBI_ASSERT(label, clk, rst_n, prop, msg)
`define GBI_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ----- hw/rtl/gbi_pkg.sv -----
`default_nettype none
package gbi_pkg;
  localparam int AXES_DEF = 3;
  localparam int TW = 40;
  localparam logic [31:0] CALIB_RST = 32'd5000000;
  localparam logic [23:0] MAXGAP_RST = 24'd500000;
  localparam logic [12:0] MIN_REPORT = 13'd18;

  typedef enum logic [2:0] {
    ST_SHORT = 3'd0, ST_CALIB = 3'd1, ST_LATCH = 3'd2, ST_GAP = 3'd3, ST_INTEG = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_DIV, S_MUL, S_ACC, S_OUT
  } fsm_t;

  typedef enum logic [0:0] {
    CFG_CALIB = 1'b0, CFG_MAXGAP = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic    load;
    logic    take_status;
    logic    calib_step;
    logic    div_start;
    logic    latch_bias;
    logic    mul_step;
    logic    acc_step;
    logic    integ_done;
    logic    set_time;
  } cmd_t;

  typedef struct packed {
    status_t cls;
    logic    div_busy;
    logic    last_axis;
  } sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/gbi_if.sv -----
`default_nettype none
interface gbi_in_if;
  logic        valid;
  logic        ready;
  logic [39:0] time_us;
  logic [12:0] report_length;
  logic signed [31:0] rate_x;
  logic signed [31:0] rate_y;
  logic signed [31:0] rate_z;
  modport source (output valid, time_us, report_length, rate_x, rate_y, rate_z, input ready);
  modport sink (input valid, time_us, report_length, rate_x, rate_y, rate_z, output ready);
endinterface

interface gbi_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic signed [63:0] heading_x;
  logic signed [63:0] heading_y;
  logic signed [63:0] heading_z;
  logic signed [63:0] peak_x;
  logic signed [63:0] peak_y;
  logic signed [63:0] peak_z;
  logic [31:0] run_count;
  logic [31:0] calib_count;
  modport source (output valid, status, heading_x, heading_y, heading_z, peak_x, peak_y,
                  peak_z, run_count, calib_count, input ready);
  modport sink (input valid, status, heading_x, heading_y, heading_z, peak_x, peak_y,
                peak_z, run_count, calib_count, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/gbi_div.sv -----
`default_nettype none
// restoring divider, one quotient bit per cycle, signed dividend truncated
module gbi_div import gbi_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic signed [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic signed [31:0] quotient
);
  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] trial;
  logic [63:0] qneg;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    neg_nxt = neg_r;
    trial = {rem_r[31:0], q_r[63]} - {1'b0, divisor};
    if (start) begin
      neg_nxt = dividend[63];
      q_nxt = dividend[63] ? (64'd0 - dividend) : dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
    end else if (cnt_r != 7'd0) begin
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[63]};
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    neg_r <= neg_nxt;
  end

  assign qneg = 64'd0 - q_r;
  assign busy = (cnt_r != 7'd0);
  assign quotient = neg_r ? qneg[31:0] : q_r[31:0];
endmodule
`default_nettype wire

// ----- hw/rtl/gbi_datapath.sv -----
`default_nettype none
`include "gyro_bias_calibrate_integrate_macros.svh"
module gbi_datapath import gbi_pkg::*; #(
  parameter int AXES = AXES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  cmd_t             cmd,
  output sts_t             sts,
  input  wire logic [31:0] calib_us,
  input  wire logic [23:0] max_gap_us,
  input  wire logic [39:0] in_time,
  input  wire logic [12:0] in_len,
  input  wire logic signed [31:0] in_rate [3],
  output logic [2:0]       o_status,
  output logic [63:0]      o_head [3],
  output logic [63:0]      o_peak [3],
  output logic [31:0]      o_run,
  output logic [31:0]      o_calib
);
  localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

  logic [39:0] t_r;
  logic [12:0] len_r;
  logic signed [31:0] rate_r [3];
  logic signed [63:0] sum_r [3];
  logic signed [31:0] bias_r [3];
  logic [63:0] head_r [3];
  logic [63:0] peak_r [3];
  logic [31:0] csmp_r, run_r;
  logic        cal_r;
  logic [39:0] last_r;
  logic [AW-1:0] ax_r;
  logic [AW-1:0] div_ax;
  logic signed [63:0] prod_r;
  logic [23:0] dt_r;
  status_t     cls;
  logic [40:0] dt;
  logic        div_busy;
  logic signed [31:0] quo;
  logic signed [32:0] diff;
  logic signed [57:0] mul_w;
  logic [63:0] newh, magh, magp;

  assign dt = {1'b0, t_r} - {1'b0, last_r};

  always_comb begin
    if (len_r < MIN_REPORT) cls = ST_SHORT;
    else if (t_r < {8'd0, calib_us}) cls = ST_CALIB;
    else if (!cal_r) cls = ST_LATCH;
    else if (dt[40] || dt == '0 || dt > {17'd0, max_gap_us}) cls = ST_GAP;
    else cls = ST_INTEG;
  end

  // next division starts in the cycle the current axis is latched
  assign div_ax = (cmd.latch_bias && !sts.last_axis) ? ax_r + AW'(1) : ax_r;

  gbi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start), .dividend(sum_r[div_ax]),
    .divisor(csmp_r), .busy(div_busy), .quotient(quo)
  );

  assign diff = 33'(rate_r[ax_r]) - 33'(bias_r[ax_r]);
  assign mul_w = diff * $signed({1'b0, dt_r});
  assign newh = head_r[ax_r] + prod_r;
  assign magh = newh[63] ? 64'd0 - newh : newh;
  assign magp = peak_r[ax_r][63] ? 64'd0 - peak_r[ax_r] : peak_r[ax_r];

  assign sts.cls = cls;
  assign sts.div_busy = div_busy;
  assign sts.last_axis = (ax_r == AW'(AXES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        sum_r[i] <= '0;
        bias_r[i] <= '0;
        head_r[i] <= '0;
        peak_r[i] <= '0;
      end
      csmp_r <= '0;
      run_r <= '0;
      cal_r <= 1'b0;
      last_r <= '0;
      ax_r <= '0;
      o_status <= '0;
    end else begin
      if (cmd.load) ax_r <= '0;
      if (cmd.calib_step && csmp_r != 32'hFFFF_FFFF) begin
        for (int i = 0; i < AXES; i++) sum_r[i] <= sum_r[i] + 64'(rate_r[i]);
        csmp_r <= csmp_r + 32'd1;
      end
      if (cmd.latch_bias) begin
        bias_r[ax_r] <= (csmp_r == '0) ? 32'sd0 : quo;
        cal_r <= 1'b1;
        ax_r <= sts.last_axis ? '0 : ax_r + AW'(1);
      end
      if (cmd.acc_step) begin
        head_r[ax_r] <= newh;
        if (magh > magp) peak_r[ax_r] <= newh;
        ax_r <= sts.last_axis ? '0 : ax_r + AW'(1);
      end
      if (cmd.integ_done && run_r != 32'hFFFF_FFFF) run_r <= run_r + 32'd1;
      if (cmd.set_time) last_r <= t_r;
      if (cmd.take_status) o_status <= cls;
    end
    if (cmd.load) begin
      t_r <= in_time;
      len_r <= in_len;
      for (int i = 0; i < 3; i++) rate_r[i] <= in_rate[i];
    end
    if (cmd.set_time) dt_r <= dt[23:0];
    if (cmd.mul_step) prod_r <= 64'(mul_w);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      o_head[i] = (i < AXES) ? head_r[i] : '0;
      o_peak[i] = (i < AXES) ? peak_r[i] : '0;
    end
  end
  assign o_run = run_r;
  assign o_calib = csmp_r;

  `GBI_ASSERT(a_axis_range, clk, rst_n, (ax_r <= AW'(AXES - 1)), "axis index out of range")
  `GBI_ASSERT(a_latch_once, clk, rst_n, (cmd.latch_bias |-> !cal_r || ax_r != '0),
              "bias latched twice")
  `GBI_ASSERT_NEVER(a_run_sat, clk, rst_n,
                    (cmd.integ_done && run_r == 32'hFFFF_FFFF && $past(run_r) != run_r),
                    "run count wrapped")
endmodule
`default_nettype wire

// ----- hw/rtl/gbi_ctrl.sv -----
`default_nettype none
`include "gyro_bias_calibrate_integrate_macros.svh"
module gbi_ctrl import gbi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  input  sts_t      sts,
  output cmd_t      cmd
);
  fsm_t st_r, st_nxt;
  logic div_go_r, div_go_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      div_go_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      div_go_r <= div_go_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    div_go_nxt = 1'b0;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          st_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.take_status = 1'b1;
        case (sts.cls)
          ST_SHORT: st_nxt = S_OUT;
          ST_CALIB: begin
            cmd.calib_step = 1'b1;
            cmd.set_time = 1'b1;
            st_nxt = S_OUT;
          end
          ST_LATCH: begin
            cmd.div_start = 1'b1;
            div_go_nxt = 1'b1;
            st_nxt = S_DIV;
          end
          ST_GAP: begin
            cmd.set_time = 1'b1;
            st_nxt = S_OUT;
          end
          default: begin
            cmd.set_time = 1'b1;
            st_nxt = S_MUL;
          end
        endcase
      end
      S_DIV: begin
        if (!div_go_r && !sts.div_busy) begin
          cmd.latch_bias = 1'b1;
          if (sts.last_axis) begin
            cmd.set_time = 1'b1;
            st_nxt = S_OUT;
          end else begin
            cmd.div_start = 1'b1;
            div_go_nxt = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        st_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_step = 1'b1;
        if (sts.last_axis) begin
          cmd.integ_done = 1'b1;
          st_nxt = S_OUT;
        end else begin
          st_nxt = S_MUL;
        end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  `GBI_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready |=> out_valid),
              "result dropped")
  `GBI_ASSERT_NEVER(a_excl, clk, rst_n, (in_ready && out_valid), "ready while result pending")
  `GBI_ASSERT(a_load_eval, clk, rst_n, (cmd.load |=> st_r == S_EVAL), "load not evaluated")
endmodule
`default_nettype wire

// ----- hw/rtl/gyro_bias_calibrate_integrate.sv -----
// Sequencing: after the accepting cycle the item is evaluated; short/calibrate/gap items then
// raise out_valid, integrate items take a multiply and an accumulate step per axis (shared multiplier),
// and the bias latch runs a 64-step restoring divider plus a latch per axis before out_valid rises.
// Throughput: one item at a time, next item taken the cycle after the result is taken.
// Reset (rst_n, synchronous): all sums, biases, headings, peaks and counters clear;
// calib_us = 5000000, max_gap_us = 500000.
`default_nettype none
module gyro_bias_calibrate_integrate import gbi_pkg::*; #(
  parameter int AXES = AXES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gbi_in_if.sink     in_ch,
  gbi_out_if.source  out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [31:0] calib_r;
  logic [23:0] gap_r;
  cmd_t cmd;
  sts_t sts;
  logic signed [31:0] rates [3];
  logic [63:0] hd [3];
  logic [63:0] pk [3];
  logic wr;
  cfg_idx_t idx;

  assign cfg_pready = 1'b1;
  assign idx = cfg_idx_t'(cfg_paddr[2]);
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      calib_r <= CALIB_RST;
      gap_r <= MAXGAP_RST;
    end else if (wr) begin
      case (idx)
        CFG_CALIB: calib_r <= cfg_pwdata;
        CFG_MAXGAP: gap_r <= cfg_pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      CFG_CALIB: cfg_prdata = calib_r;
      CFG_MAXGAP: cfg_prdata = {8'd0, gap_r};
      default: cfg_prdata = '0;
    endcase
  end

  assign rates[0] = in_ch.rate_x;
  assign rates[1] = in_ch.rate_y;
  assign rates[2] = in_ch.rate_z;

  gbi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
  );

  gbi_datapath #(.AXES(AXES)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .calib_us(calib_r),
    .max_gap_us(gap_r), .in_time(in_ch.time_us), .in_len(in_ch.report_length),
    .in_rate(rates), .o_status(out_ch.status), .o_head(hd), .o_peak(pk),
    .o_run(out_ch.run_count), .o_calib(out_ch.calib_count)
  );

  assign out_ch.heading_x = hd[0];
  assign out_ch.heading_y = hd[1];
  assign out_ch.heading_z = hd[2];
  assign out_ch.peak_x = pk[0];
  assign out_ch.peak_y = pk[1];
  assign out_ch.peak_z = pk[2];
endmodule
`default_nettype wire

// ----- tb/sv/gyro_bias_calibrate_integrate_test.sv -----
`timescale 1ns / 100ps
module gyro_bias_calibrate_integrate_test;
  import gbi_pkg::*;

  typedef struct {
    status_t     status;
    logic [63:0] head[3];
    logic [63:0] peak[3];
    logic [31:0] run_n;
    logic [31:0] calib_n;
  } heading_result_t;

  class heading_scoreboard;
    bit [31:0]       calib_us;
    bit [23:0]       max_gap_us;
    longint          bias_sum[3];
    bit [31:0]       calib_n;
    longint          bias[3];
    bit              latched;
    bit [39:0]       last_t;
    bit [63:0]       head[3];
    bit [63:0]       peak[3];
    bit [31:0]       run_n;
    heading_result_t pending[$];
    int              errors;

    function new();
      calib_us = CALIB_RST;
      max_gap_us = MAXGAP_RST;
      for (int i = 0; i < 3; i++) begin
        bias_sum[i] = 0;
        bias[i] = 0;
        head[i] = 0;
        peak[i] = 0;
      end
      calib_n = 0;
      latched = 0;
      last_t = 0;
      run_n = 0;
      errors = 0;
    endfunction

    function bit [63:0] mag(bit [63:0] h);
      return h[63] ? 64'd0 - h : h;
    endfunction

    function void set_reg(cfg_idx_t idx, bit [31:0] val);
      if (idx == CFG_CALIB) calib_us = val;
      else max_gap_us = val[23:0];
    endfunction

    function void note_sample(bit [39:0] t, bit [12:0] len, int rx, int ry, int rz);
      heading_result_t r;
      int              rate[3];
      longint          dt;
      longint          prod;
      rate[0] = rx;
      rate[1] = ry;
      rate[2] = rz;
      if (len < MIN_REPORT) begin
        r.status = ST_SHORT;
      end else if (t < {8'd0, calib_us}) begin
        r.status = ST_CALIB;
        if (calib_n != 32'hFFFF_FFFF) begin
          for (int i = 0; i < 3; i++) bias_sum[i] += longint'(rate[i]);
          calib_n++;
        end
        last_t = t;
      end else if (!latched) begin
        r.status = ST_LATCH;
        latched = 1;
        for (int i = 0; i < 3; i++)
          bias[i] = (calib_n != 0) ? bias_sum[i] / longint'({32'd0, calib_n}) : 0;
        last_t = t;
      end else begin
        dt = longint'({24'd0, t}) - longint'({24'd0, last_t});
        last_t = t;
        if (dt <= 0 || dt > longint'({40'd0, max_gap_us})) begin
          r.status = ST_GAP;
        end else begin
          r.status = ST_INTEG;
          if (run_n != 32'hFFFF_FFFF) run_n++;
          for (int i = 0; i < 3; i++) begin
            prod = (longint'(rate[i]) - bias[i]) * dt;
            head[i] += prod;
            if (mag(head[i]) > mag(peak[i])) peak[i] = head[i];
          end
        end
      end
      for (int i = 0; i < 3; i++) begin
        r.head[i] = head[i];
        r.peak[i] = peak[i];
      end
      r.run_n = run_n;
      r.calib_n = calib_n;
      pending.push_back(r);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s mismatch got %h expected %h", $realtime, field, got, want);
      errors++;
    endtask

    task check_result(heading_result_t got);
      heading_result_t want;
      if (pending.size() == 0) begin
        report("unexpected item", {61'd0, got.status}, 64'd0);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) report("status", got.status, want.status);
      for (int i = 0; i < 3; i++) begin
        if (got.head[i] !== want.head[i]) report($sformatf("heading[%0d]", i), got.head[i],
                                                 want.head[i]);
        if (got.peak[i] !== want.peak[i]) report($sformatf("peak[%0d]", i), got.peak[i],
                                                 want.peak[i]);
      end
      if (got.run_n !== want.run_n) report("run_count", got.run_n, want.run_n);
      if (got.calib_n !== want.calib_n) report("calib_count", got.calib_n, want.calib_n);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  gbi_in_if  in_ch();
  gbi_out_if out_ch();

  gyro_bias_calibrate_integrate i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  heading_scoreboard heading_sb = new();
  bit                no_idle;
  int                out_stall;
  int                quiet_cycles;
  logic [39:0]       cur_t;
  bit [23:0]         cur_gap;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function int idle_len();
    int k;
    if (no_idle) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        heading_result_t got;
        got.status = status_t'(out_ch.status);
        got.head[0] = out_ch.heading_x;
        got.head[1] = out_ch.heading_y;
        got.head[2] = out_ch.heading_z;
        got.peak[0] = out_ch.peak_x;
        got.peak[1] = out_ch.peak_y;
        got.peak[2] = out_ch.peak_z;
        got.run_n = out_ch.run_count;
        got.calib_n = out_ch.calib_count;
        heading_sb.check_result(got);
      end
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else begin
        out_stall = idle_len();
        out_ch.ready <= (out_stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= 5000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    heading_sb.set_reg(idx, val);
    if (idx == CFG_MAXGAP) cur_gap = val[23:0];
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (heading_sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic send_sample(logic [39:0] t, logic [12:0] len, int rx, int ry, int rz);
    int g;
    in_ch.time_us <= t;
    in_ch.report_length <= len;
    in_ch.rate_x <= rx;
    in_ch.rate_y <= ry;
    in_ch.rate_z <= rz;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    heading_sb.note_sample(t, len, rx, ry, rz);
    g = idle_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  function int rand_rate();
    if ($urandom_range(0, 1)) return int'($urandom);
    return int'($urandom_range(0, 200000)) - 100000;
  endfunction

  task automatic random_samples(int n);
    int          k;
    logic [12:0] len;
    for (int j = 0; j < n; j++) begin
      k = $urandom_range(0, 99);
      len = (k < 8) ? 13'($urandom_range(0, 17)) : 13'($urandom_range(18, 4096));
      k = $urandom_range(0, 99);
      if (k < 5) cur_t = cur_t;
      else if (k < 10) cur_t = cur_t - 40'($urandom_range(1, 1000));
      else if (k < 15) cur_t = cur_t + 40'(cur_gap) + 40'($urandom_range(1, 1000));
      else if (k < 20) cur_t = 40'({$urandom, $urandom});
      else cur_t = cur_t + 40'($urandom_range(1, (cur_gap == 0) ? 1 : cur_gap));
      send_sample(cur_t, len, rand_rate(), rand_rate(), rand_rate());
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.time_us = '0;
    in_ch.report_length = '0;
    in_ch.rate_x = '0;
    in_ch.rate_y = '0;
    in_ch.rate_z = '0;
    no_idle = 0;
    cur_gap = MAXGAP_RST;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    write_reg(CFG_CALIB, 32'd1000);
    write_reg(CFG_MAXGAP, 32'd100);
    send_sample(40'd0, 13'd0, 32'sh7FFF_FFFF, -32'sd1, 32'sd5);
    send_sample(40'd5, 13'd17, 32'sd1, 32'sd1, 32'sd1);
    send_sample(40'd0, 13'd4096, 32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd7);
    send_sample(40'd10, 13'd18, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd4);
    send_sample(40'd999, 13'd100, -32'sd3, 32'sd0, 32'sd9);
    send_sample(40'd1000, 13'd100, 32'sd0, 32'sd0, 32'sd0);
    send_sample(40'd1050, 13'd64, 32'sd1000, -32'sd1000, 32'sd0);
    send_sample(40'd1050, 13'd64, 32'sd1, 32'sd1, 32'sd1);
    send_sample(40'd1150, 13'd64, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd100);
    send_sample(40'd1251, 13'd64, 32'sd1, 32'sd1, 32'sd1);
    send_sample(40'd1200, 13'd64, 32'sd1, 32'sd1, 32'sd1);
    send_sample(40'd1201, 13'd4096, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1);
    send_sample(40'hFF_FFFF_FFFF, 13'd20, 32'sd1, 32'sd1, 32'sd1);
    send_sample(40'hFF_FFFF_FFFF, 13'd10, 32'sd1, 32'sd1, 32'sd1);
    cur_t = 40'hFF_FFFF_FFFF;

    no_idle = 1;
    random_samples(60);
    no_idle = 0;
    random_samples(100);
    drain();
    random_samples(120);

    drain();
    write_reg(CFG_CALIB, 32'd0);
    write_reg(CFG_MAXGAP, 32'hFF_FFFF);
    random_samples(250);

    drain();
    write_reg(CFG_CALIB, 32'hFFFF_FFFF);
    write_reg(CFG_MAXGAP, 32'd1);
    random_samples(150);

    drain();
    write_reg(CFG_CALIB, CALIB_RST);
    write_reg(CFG_MAXGAP, 32'(MAXGAP_RST));
    random_samples(150);
    in_ch.valid <= 1'b0;

    drain();
    repeat (300) @(posedge clk);
    if (heading_sb.pending.size() != 0) heading_sb.errors++;
    if (heading_sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/gbi_pkg.sv
hw/rtl/gbi_if.sv
hw/rtl/gbi_div.sv
hw/rtl/gbi_datapath.sv
hw/rtl/gbi_ctrl.sv
hw/rtl/gyro_bias_calibrate_integrate.sv
tb/sv/gyro_bias_calibrate_integrate_test.sv
